>>> hdl/ttuv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the triangle tangent block.
package ttuv_pkg;

	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 59;
	localparam int NORM_TOP = 30;
	localparam int UNIT_SHIFT = 14;
	localparam int QUO_W = UNIT_SHIFT + 1;
	localparam int LEN_W = 31;
	localparam int NUM_W = NORM_TOP + UNIT_SHIFT + 1;
	localparam int SQ_W = 64;
	localparam int T_LAST = 8;
	localparam int S_LAST = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_T,
		ST_CHECK,
		ST_NORM,
		ST_MUL_S,
		ST_SQRT,
		ST_DLOAD,
		ST_DIV,
		ST_DONE
	} ttuv_state_t;

endpackage

>>> hdl/ttuv_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module ttuv_mul (
	input  logic                                clk,
	input  logic signed [ttuv_pkg::MUL_W-1:0]   a,
	input  logic signed [ttuv_pkg::MUL_W-1:0]   b,
	output logic signed [ttuv_pkg::PROD_W-1:0]  p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

>>> hdl/triangle_tangent_from_uv_core.sv
`timescale 1ns / 1ps
// Top level: per-triangle tangent from uv deltas with one shared multiplier.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | pos_x, pos_y, pos_z, tex_u, tex_v
//  out     | output    | out_valid / out_stall | tangent_x, tangent_y, tangent_z, degenerate
//
// The first two vertices of a triangle are stored without stalling the input.
// The third vertex starts a sequence: eight products on the shared multiplier, a
// one-bit-a-cycle normalizing shift, three squares, a 32-step root and three 15-step
// divisions. A degenerate triangle goes from the check straight to the final write.
// Reset clears the vertex slot, the sequencer and the output valid; no clearing pass.
// A result waiting under out_stall holds the block only at its final write.
module triangle_tangent_from_uv_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [23:0] tex_u,
	input  logic signed [23:0] tex_v,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_y,
	output logic signed [15:0] tangent_z,
	output logic               degenerate
);

	ttuv_pkg::ttuv_state_t state_q, state_d;

	logic [1:0] vslot_q;
	logic [1:0] slot_eff;
	logic [4:0] cnt_q;
	logic [1:0] dk_q;
	logic       out_valid_q;
	logic       in_acc;
	logic       out_free;

	logic signed [31:0] hpos_q [6];
	logic signed [23:0] htex_q [4];

	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic signed [24:0] du1_q, dv1_q, du2_q, dv2_q;

	logic signed [ttuv_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [ttuv_pkg::PROD_W-1:0] prod_s1;

	logic signed [ttuv_pkg::ACC_W-1:0] acc_q [4];
	logic [ttuv_pkg::ACC_W-1:0] r_q [3];
	logic [ttuv_pkg::ACC_W-1:0] r_c [3];
	logic [2:0] neg_q, neg_c;
	logic [ttuv_pkg::ACC_W-1:0] r_or;
	logic norm_hi, norm_lo, degen_c;
	logic [2:0] tj;
	logic [1:0] sj;

	logic [ttuv_pkg::SQ_W-1:0] sum_q, rem_q, res_q, bit_q, trial;
	logic [ttuv_pkg::NUM_W-1:0] drem_q, dsr_q;
	logic [ttuv_pkg::QUO_W-1:0] quo_q, quo_n;
	logic div_ge;

	logic signed [15:0] tan_q [3];
	logic               deg_q;
	logic signed [15:0] otx_q, oty_q, otz_q;
	logic               odeg_q;

	ttuv_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (prod_s1)
	);

	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	// A slot value of three cannot arise, but it is handled as slot zero.
	assign slot_eff = (vslot_q == 2'd3) ? 2'd0 : vslot_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r_c[k] = acc_q[k+1][ttuv_pkg::ACC_W-1] ? ttuv_pkg::ACC_W'(-acc_q[k+1])
				: ttuv_pkg::ACC_W'(acc_q[k+1]);
			neg_c[k] = acc_q[k+1][ttuv_pkg::ACC_W-1] ^ acc_q[0][ttuv_pkg::ACC_W-1];
		end
	end
	assign degen_c = (acc_q[0] == '0) || ((r_c[0] | r_c[1] | r_c[2]) == '0);
	assign r_or = r_q[0] | r_q[1] | r_q[2];
	assign norm_hi = |r_or[ttuv_pkg::ACC_W-1:ttuv_pkg::NORM_TOP];
	assign norm_lo = !r_or[ttuv_pkg::NORM_TOP-1];
	assign tj = 3'(cnt_q - 5'd1);
	assign sj = 2'(cnt_q - 5'd1);
	assign trial = res_q + bit_q;
	assign div_ge = drem_q >= dsr_q;
	assign quo_n = {quo_q[ttuv_pkg::QUO_W-2:0], div_ge};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttuv_pkg::ST_IDLE:  if (in_acc && slot_eff == 2'd2) state_d = ttuv_pkg::ST_MUL_T;
			ttuv_pkg::ST_MUL_T: if (cnt_q == 5'(ttuv_pkg::T_LAST)) state_d = ttuv_pkg::ST_CHECK;
			ttuv_pkg::ST_CHECK: state_d = degen_c ? ttuv_pkg::ST_DONE : ttuv_pkg::ST_NORM;
			ttuv_pkg::ST_NORM:  if (!norm_hi && !norm_lo) state_d = ttuv_pkg::ST_MUL_S;
			ttuv_pkg::ST_MUL_S: if (cnt_q == 5'(ttuv_pkg::S_LAST)) state_d = ttuv_pkg::ST_SQRT;
			ttuv_pkg::ST_SQRT:  if (bit_q[0]) state_d = ttuv_pkg::ST_DLOAD;
			ttuv_pkg::ST_DLOAD: state_d = ttuv_pkg::ST_DIV;
			ttuv_pkg::ST_DIV: begin
				if (cnt_q == 5'(ttuv_pkg::QUO_W - 1))
					state_d = (dk_q == 2'd2) ? ttuv_pkg::ST_DONE : ttuv_pkg::ST_DLOAD;
			end
			ttuv_pkg::ST_DONE:  if (out_free) state_d = ttuv_pkg::ST_IDLE;
			default:            state_d = ttuv_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: input stall and multiplier operands.
	always_comb begin
		in_stall = (state_q != ttuv_pkg::ST_IDLE);
		mul_a = '0;
		mul_b = '0;
		if (state_q == ttuv_pkg::ST_MUL_T) begin
			case (cnt_q)
				5'd0: begin
					mul_a = ttuv_pkg::MUL_W'(du1_q);
					mul_b = ttuv_pkg::MUL_W'(dv2_q);
				end
				5'd1: begin
					mul_a = ttuv_pkg::MUL_W'(du2_q);
					mul_b = ttuv_pkg::MUL_W'(dv1_q);
				end
				5'd2: begin
					mul_a = ttuv_pkg::MUL_W'(dv2_q);
					mul_b = e1_q[0];
				end
				5'd3: begin
					mul_a = ttuv_pkg::MUL_W'(dv1_q);
					mul_b = e2_q[0];
				end
				5'd4: begin
					mul_a = ttuv_pkg::MUL_W'(dv2_q);
					mul_b = e1_q[1];
				end
				5'd5: begin
					mul_a = ttuv_pkg::MUL_W'(dv1_q);
					mul_b = e2_q[1];
				end
				5'd6: begin
					mul_a = ttuv_pkg::MUL_W'(dv2_q);
					mul_b = e1_q[2];
				end
				5'd7: begin
					mul_a = ttuv_pkg::MUL_W'(dv1_q);
					mul_b = e2_q[2];
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == ttuv_pkg::ST_MUL_S && cnt_q < 5'(ttuv_pkg::S_LAST)) begin
			mul_a = {3'b000, r_q[cnt_q[1:0]][ttuv_pkg::NORM_TOP-1:0]};
			mul_b = {3'b000, r_q[cnt_q[1:0]][ttuv_pkg::NORM_TOP-1:0]};
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttuv_pkg::ST_IDLE;
			vslot_q <= 2'd0;
			cnt_q <= '0;
			dk_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) vslot_q <= (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
			if (state_q == ttuv_pkg::ST_MUL_T || state_q == ttuv_pkg::ST_MUL_S ||
				state_q == ttuv_pkg::ST_DIV)
				cnt_q <= cnt_q + 5'd1;
			else
				cnt_q <= '0;
			if (state_q == ttuv_pkg::ST_CHECK)
				dk_q <= '0;
			else if (state_q == ttuv_pkg::ST_DIV && cnt_q == 5'(ttuv_pkg::QUO_W - 1))
				dk_q <= dk_q + 2'd1;
			if (state_q == ttuv_pkg::ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (slot_eff == 2'd0) begin
				hpos_q[0] <= pos_x;
				hpos_q[1] <= pos_y;
				hpos_q[2] <= pos_z;
				htex_q[0] <= tex_u;
				htex_q[1] <= tex_v;
			end else if (slot_eff == 2'd1) begin
				hpos_q[3] <= pos_x;
				hpos_q[4] <= pos_y;
				hpos_q[5] <= pos_z;
				htex_q[2] <= tex_u;
				htex_q[3] <= tex_v;
			end else begin
				e1_q[0] <= 33'(hpos_q[3]) - 33'(hpos_q[0]);
				e1_q[1] <= 33'(hpos_q[4]) - 33'(hpos_q[1]);
				e1_q[2] <= 33'(hpos_q[5]) - 33'(hpos_q[2]);
				e2_q[0] <= 33'(pos_x) - 33'(hpos_q[0]);
				e2_q[1] <= 33'(pos_y) - 33'(hpos_q[1]);
				e2_q[2] <= 33'(pos_z) - 33'(hpos_q[2]);
				du1_q <= 25'(htex_q[2]) - 25'(htex_q[0]);
				dv1_q <= 25'(htex_q[3]) - 25'(htex_q[1]);
				du2_q <= 25'(tex_u) - 25'(htex_q[0]);
				dv2_q <= 25'(tex_v) - 25'(htex_q[1]);
			end
		end

		// Products arrive in the cycle after their operands; even terms load, odd terms subtract.
		if (state_q == ttuv_pkg::ST_MUL_T && cnt_q != 5'd0) begin
			if (!tj[0])
				acc_q[tj[2:1]] <= prod_s1[ttuv_pkg::ACC_W-1:0];
			else
				acc_q[tj[2:1]] <= acc_q[tj[2:1]] - prod_s1[ttuv_pkg::ACC_W-1:0];
		end

		if (state_q == ttuv_pkg::ST_CHECK) begin
			r_q <= r_c;
			neg_q <= neg_c;
			deg_q <= degen_c;
			for (int k = 0; k < 3; k++) tan_q[k] <= '0;
		end

		// One bit of shift per cycle until the largest magnitude has its top set bit at bit 29.
		if (state_q == ttuv_pkg::ST_NORM) begin
			for (int k = 0; k < 3; k++) begin
				if (norm_hi)
					r_q[k] <= r_q[k] >> 1;
				else if (norm_lo)
					r_q[k] <= r_q[k] << 1;
			end
		end

		if (state_q == ttuv_pkg::ST_MUL_S && cnt_q != 5'd0) begin
			if (sj == 2'd0)
				sum_q <= ttuv_pkg::SQ_W'(prod_s1);
			else
				sum_q <= sum_q + ttuv_pkg::SQ_W'(prod_s1);
			if (cnt_q == 5'(ttuv_pkg::S_LAST)) begin
				rem_q <= sum_q + ttuv_pkg::SQ_W'(prod_s1);
				res_q <= '0;
				bit_q <= {2'b01, {(ttuv_pkg::SQ_W - 2){1'b0}}};
			end
		end

		if (state_q == ttuv_pkg::ST_SQRT) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end

		if (state_q == ttuv_pkg::ST_DLOAD) begin
			drem_q <= {1'b0, r_q[dk_q][ttuv_pkg::NORM_TOP-1:0], {ttuv_pkg::UNIT_SHIFT{1'b0}}}
				+ ttuv_pkg::NUM_W'(res_q[ttuv_pkg::LEN_W-1:1]);
			dsr_q <= {res_q[ttuv_pkg::LEN_W-1:0], {ttuv_pkg::UNIT_SHIFT{1'b0}}};
			quo_q <= '0;
		end

		if (state_q == ttuv_pkg::ST_DIV) begin
			if (div_ge) drem_q <= drem_q - dsr_q;
			dsr_q <= dsr_q >> 1;
			quo_q <= quo_n;
			if (cnt_q == 5'(ttuv_pkg::QUO_W - 1))
				tan_q[dk_q] <= neg_q[dk_q] ? -$signed({1'b0, quo_n}) : $signed({1'b0, quo_n});
		end

		if (state_q == ttuv_pkg::ST_DONE && out_free) begin
			otx_q <= tan_q[0];
			oty_q <= tan_q[1];
			otz_q <= tan_q[2];
			odeg_q <= deg_q;
		end
	end

	assign out_valid = out_valid_q;
	assign tangent_x = otx_q;
	assign tangent_y = oty_q;
	assign tangent_z = otz_q;
	assign degenerate = odeg_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> tangent_x == 16'sd0 && tangent_y == 16'sd0 &&
			tangent_z == 16'sd0)
		else $error("degenerate word carries a nonzero tangent");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> tangent_x <= 16'sd16384 && tangent_x >= -16'sd16384 &&
			tangent_y <= 16'sd16384 && tangent_y >= -16'sd16384 &&
			tangent_z <= 16'sd16384 && tangent_z >= -16'sd16384)
		else $error("tangent component outside the unit range");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ttuv_pkg::ST_DONE))
		else $error("output word raised outside the final write");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vslot_q != 2'd3)
		else $error("vertex slot left its range");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle tangent core.
module testbench;

	typedef struct {
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic signed [15:0] tz;
		logic               degen;
	} tangent_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [23:0] tex_u;
	logic signed [23:0] tex_v;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] tangent_x;
	logic signed [15:0] tangent_y;
	logic signed [15:0] tangent_z;
	logic               degenerate;

	tangent_t expected_tangents[$];
	int errors;
	int hold_cycles;
	bit long_hold;

	// Predictor state: vertices of the triangle being collected.
	logic [1:0]         corner;
	logic signed [31:0] held_pos[2][3];
	logic signed [23:0] held_uv[2][2];

	triangle_tangent_from_uv_core DUT (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("triangle_tangent_from_uv_core: mismatch");
		$finish;
	end

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic tangent_t triangle_tangent(logic signed [31:0] p[3][3],
			logic signed [23:0] uv[3][2]);
		tangent_t res;
		longint du1, dv1, du2, dv2, det;
		longint tv[3];
		longint unsigned r[3];
		longint unsigned m, s, len, q;
		int nb;
		du1 = longint'(uv[1][0]) - longint'(uv[0][0]);
		dv1 = longint'(uv[1][1]) - longint'(uv[0][1]);
		du2 = longint'(uv[2][0]) - longint'(uv[0][0]);
		dv2 = longint'(uv[2][1]) - longint'(uv[0][1]);
		det = du1 * dv2 - du2 * dv1;
		m = 0;
		for (int k = 0; k < 3; k++) begin
			tv[k] = dv2 * (longint'(p[1][k]) - longint'(p[0][k]))
				- dv1 * (longint'(p[2][k]) - longint'(p[0][k]));
			r[k] = tv[k] < 0 ? -tv[k] : tv[k];
			if (r[k] > m)
				m = r[k];
		end
		res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
		if (det == 0 || m == 0)
			return res;
		nb = 0;
		while ((m >> nb) != 0)
			nb++;
		for (int k = 0; k < 3; k++)
			r[k] = nb > 30 ? r[k] >> (nb - 30) : r[k] << (30 - nb);
		s = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
		len = root_floor(s);
		res.degen = 1'b0;
		for (int k = 0; k < 3; k++) begin
			q = (r[k] * 16384 + (len >> 1)) / len;
			if ((tv[k] < 0) != (det < 0))
				q = -q;
			if (k == 0) res.tx = q[15:0];
			else if (k == 1) res.ty = q[15:0];
			else res.tz = q[15:0];
		end
		return res;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("error %0t: %s got %0d expected %0d", $realtime, what, $signed(got),
			$signed(want));
		errors++;
	endtask

	task automatic predict_vertex(logic signed [31:0] x, y, z, logic signed [23:0] u, v);
		logic signed [31:0] p[3][3];
		logic signed [23:0] uv[3][2];
		if (corner < 2) begin
			held_pos[corner] = '{x, y, z};
			held_uv[corner] = '{u, v};
			corner++;
		end else begin
			p[0] = held_pos[0];
			p[1] = held_pos[1];
			p[2] = '{x, y, z};
			uv[0] = held_uv[0];
			uv[1] = held_uv[1];
			uv[2] = '{u, v};
			expected_tangents = {expected_tangents, triangle_tangent(p, uv)};
			corner = 0;
		end
	endtask

	// The input drops its valid only when a real gap follows.
	task automatic random_gap();
		int g;
		g = $urandom_range(0, 99);
		if (g < 55)
			g = 0;
		else if (g < 95)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(10, 40);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Offer one word and hold it until the core takes it.
	task automatic send_vertex(logic signed [31:0] x, y, z, logic signed [23:0] u, v,
			bit gaps = 1);
		if (gaps)
			random_gap();
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		tex_u <= u;
		tex_v <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_vertex(x, y, z, u, v);
	endtask

	function automatic logic signed [31:0] rand_pos(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $signed($urandom) >>> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic signed [23:0] rand_uv(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(0, 200)) - 100);
			default: return $signed(24'($urandom)) >>> $urandom_range(0, 23);
		endcase
	endfunction

	task automatic test_directed();
		logic signed [31:0] pmax, pmin;
		logic signed [23:0] umax, umin;
		pmax = 32'h7fffffff;
		pmin = 32'h80000000;
		umax = 24'h7fffff;
		umin = 24'h800000;
		// Plain right triangle in the xy plane.
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h10000, 0, 0, 24'h10000, 0);
		send_vertex(0, 32'h10000, 0, 0, 24'h10000);
		// Mirrored uv gives a negative determinant.
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(32'h10000, 0, 0, -24'sh10000, 0);
		send_vertex(0, 32'h10000, 0, 0, 24'h10000);
		// Zero determinant: collinear uv.
		send_vertex(5, 6, 7, 10, 10);
		send_vertex(9, 1, 2, 20, 20);
		send_vertex(3, 3, 8, 30, 30);
		// Zero tangent: all positions equal.
		send_vertex(77, 77, 77, 0, 0);
		send_vertex(77, 77, 77, 5, 0);
		send_vertex(77, 77, 77, 0, 5);
		// Field extremes, largest edges and deltas.
		send_vertex(pmin, pmax, pmin, umin, umax);
		send_vertex(pmax, pmin, pmax, umax, umin);
		send_vertex(pmin, pmin, pmax, umin, umin);
		send_vertex(pmax, pmax, pmax, umax, umax);
		send_vertex(pmin, pmin, pmin, umin, umax);
		send_vertex(pmax, pmin, 0, umax, umin);
		// Tiny tangent needs a large left shift.
		send_vertex(0, 0, 0, 0, 0);
		send_vertex(1, 0, 0, 1, 0);
		send_vertex(0, 1, -1, 0, 1);
	endtask

	task automatic test_random(int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = $urandom_range(0, 2);
			send_vertex(rand_pos(mode), rand_pos(mode), rand_pos(mode), rand_uv(mode),
				rand_uv(mode));
		end
	endtask

	// Consumer stalls stay on while the producer keeps offering back to back.
	task automatic test_backpressure();
		long_hold = 1'b1;
		for (int i = 0; i < 30; i++)
			send_vertex(rand_pos(2), rand_pos(2), rand_pos(2), rand_uv(2), rand_uv(2), 0);
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (long_hold);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_tangents.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
	endtask

	// Receiver stall pattern.
	initial begin
		int g;
		out_stall = 1'b0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				hold_cycles++;
				if (hold_cycles == 600) begin
					long_hold = 1'b0;
					hold_cycles = 0;
				end
			end else begin
				g = $urandom_range(0, 99);
				out_stall <= g < 25 || (g < 27 && $urandom_range(0, 1));
				if (g == 99)
					repeat ($urandom_range(10, 60)) @(posedge clk);
			end
		end
	end

	// Result checker.
	initial begin
		tangent_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_tangents.size() == 0) begin
					report("unexpected word", tangent_x, 16'd0);
				end else begin
					want = expected_tangents.pop_front();
					if (tangent_x !== want.tx) report("tangent_x", tangent_x, want.tx);
					if (tangent_y !== want.ty) report("tangent_y", tangent_y, want.ty);
					if (tangent_z !== want.tz) report("tangent_z", tangent_z, want.tz);
					if (degenerate !== want.degen)
						report("degenerate", 16'(degenerate), 16'(want.degen));
				end
			end
		end
	end

	initial begin
		errors = 0;
		corner = 0;
		long_hold = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		tex_u = '0;
		tex_v = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1800);
		drain();
		if (errors == 0 && expected_tangents.size() == 0)
			$display("triangle_tangent_from_uv_core: match");
		else
			$display("triangle_tangent_from_uv_core: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
hdl/ttuv_pkg.sv
hdl/ttuv_mul.sv
hdl/triangle_tangent_from_uv_core.sv
verif/testbench.sv
